// File: hdl/spd_pkg.sv
// Shared constants and controller/datapath interface types for the stereo ping-pong delay.
package spd_pkg;

    localparam int SAMPLE_BITS  = 24;
    localparam int MEM_BITS     = 2 * SAMPLE_BITS;
    localparam int DELAY_DEPTH  = 262144;
    localparam int ADDR_BITS    = $clog2(DELAY_DEPTH);
    localparam int FRAC_BITS    = 8;
    localparam int POS_BITS     = ADDR_BITS + FRAC_BITS;
    localparam int DLY_BITS     = POS_BITS + 1;
    localparam int GAIN_BITS    = 16;
    localparam int CFG_BITS     = DLY_BITS;
    localparam int CFG_IDX_BITS = 2;

    localparam logic [GAIN_BITS:0]  GAIN_ONE   = {1'b1, {GAIN_BITS{1'b0}}};
    localparam logic [DLY_BITS-1:0] DELAY_SPAN = {1'b1, {POS_BITS{1'b0}}};

    localparam logic [GAIN_BITS:0]   BALANCE_RST  = (GAIN_BITS + 1)'(32768);
    localparam logic [DLY_BITS-1:0]  DELAY_RST    = DLY_BITS'(1228800);
    localparam logic [GAIN_BITS-1:0] FEEDBACK_RST = GAIN_BITS'(45875);
    localparam logic [GAIN_BITS:0]   MIX_RST      = GAIN_ONE;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_BALANCE  = 2'd0,
        CFG_DELAY    = 2'd1,
        CFG_FEEDBACK = 2'd2,
        CFG_MIX      = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic clear_wr;
        logic load;
        logic pos;
        logic rd0;
        logic rd1;
        logic interp;
        logic blend;
        logic mix;
        logic finish;
        logic done;
    } dp_cmd_t;

    typedef struct packed {
        logic clear_last;
    } dp_sts_t;

endpackage

// File: hdl/spd_ctrl.sv
// Sequencing state machine for the stereo ping-pong delay: memory clear, per-word steps, output handshake.
module spd_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    output logic            m_valid,
    input  logic            m_ready,
    input  spd_pkg::dp_sts_t sts,
    output spd_pkg::dp_cmd_t cmd
);
    import spd_pkg::*;

    typedef enum logic [9:0] {
        ST_CLEAR  = 10'b0000000001,
        ST_IDLE   = 10'b0000000010,
        ST_POS    = 10'b0000000100,
        ST_RD0    = 10'b0000001000,
        ST_RD1    = 10'b0000010000,
        ST_INTERP = 10'b0000100000,
        ST_BLEND  = 10'b0001000000,
        ST_MIX    = 10'b0010000000,
        ST_FINISH = 10'b0100000000,
        ST_DONE   = 10'b1000000000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   m_valid_reg;
    logic   m_valid_next;
    logic   out_free;

    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:  if (sts.clear_last) state_next = ST_IDLE;
            ST_IDLE:   if (s_valid) state_next = ST_POS;
            ST_POS:    state_next = ST_RD0;
            ST_RD0:    state_next = ST_RD1;
            ST_RD1:    state_next = ST_INTERP;
            ST_INTERP: state_next = ST_BLEND;
            ST_BLEND:  state_next = ST_MIX;
            ST_MIX:    state_next = ST_FINISH;
            ST_FINISH: state_next = ST_DONE;
            ST_DONE:   if (out_free) state_next = ST_IDLE;
            default:   state_next = ST_CLEAR;
        endcase
    end

    always_comb begin
        cmd          = '0;
        cmd.clear_wr = (state_reg == ST_CLEAR);
        cmd.load     = (state_reg == ST_IDLE) && s_valid;
        cmd.pos      = (state_reg == ST_POS);
        cmd.rd0      = (state_reg == ST_RD0);
        cmd.rd1      = (state_reg == ST_RD1);
        cmd.interp   = (state_reg == ST_INTERP);
        cmd.blend    = (state_reg == ST_BLEND);
        cmd.mix      = (state_reg == ST_MIX);
        cmd.finish   = (state_reg == ST_FINISH);
        cmd.done     = (state_reg == ST_DONE) && out_free;
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.done) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;

endmodule

// File: hdl/spd_datapath.sv
// Datapath of the stereo ping-pong delay: settings, delay memory, interpolation, mixing and feedback.
module spd_datapath (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  spd_pkg::dp_cmd_t                     cmd,
    output spd_pkg::dp_sts_t                     sts,
    input  logic                                 cfg_we,
    input  logic [spd_pkg::CFG_IDX_BITS-1:0]     cfg_index,
    input  logic [spd_pkg::CFG_BITS-1:0]         cfg_wdata,
    input  logic signed [spd_pkg::SAMPLE_BITS-1:0] s_in_left,
    input  logic signed [spd_pkg::SAMPLE_BITS-1:0] s_in_right,
    output logic signed [spd_pkg::SAMPLE_BITS-1:0] m_out_left,
    output logic signed [spd_pkg::SAMPLE_BITS-1:0] m_out_right
);
    import spd_pkg::*;

    localparam int SB       = SAMPLE_BITS;
    localparam int WP_BITS  = SB + GAIN_BITS + 2;
    localparam int IP_BITS  = SB + FRAC_BITS + 2;
    localparam int MX_BITS  = SB + GAIN_BITS + 4;
    localparam int FB_BITS  = SB + GAIN_BITS + 2;
    localparam int SUM_BITS = SB + 3;

    localparam logic signed [WP_BITS-1:0] WP_HALF = WP_BITS'(1) <<< (GAIN_BITS - 1);
    localparam logic signed [IP_BITS-1:0] IP_HALF = IP_BITS'(1) <<< (FRAC_BITS - 1);
    localparam logic signed [MX_BITS-1:0] MX_HALF = MX_BITS'(1) <<< (GAIN_BITS - 1);
    localparam logic signed [FB_BITS-1:0] FB_HALF = FB_BITS'(1) <<< (GAIN_BITS - 1);
    localparam logic signed [SUM_BITS-1:0] S_MAX  = SUM_BITS'((64'd1 << (SB - 1)) - 64'd1);
    localparam logic signed [SUM_BITS-1:0] S_MIN  = -S_MAX - SUM_BITS'(1);
    localparam logic [ADDR_BITS-1:0] LAST_ADDR    = ADDR_BITS'(DELAY_DEPTH - 1);

    function automatic logic [SB-1:0] sat_sample(input logic signed [SUM_BITS-1:0] v);
        logic [SB-1:0] r;
        if (v > S_MAX) begin
            r = S_MAX[SB-1:0];
        end else if (v < S_MIN) begin
            r = S_MIN[SB-1:0];
        end else begin
            r = v[SB-1:0];
        end
        return r;
    endfunction

    // Settings; balance, delay and mix are stored already clamped to their legal ranges.
    logic [GAIN_BITS:0]   bal_reg;
    logic [DLY_BITS-1:0]  dly_reg;
    logic [GAIN_BITS-1:0] fb_reg;
    logic [GAIN_BITS:0]   mix_reg;
    logic [GAIN_BITS:0]   cfg_gain;
    logic [GAIN_BITS:0]   cfg_gain_clamped;
    logic [DLY_BITS-1:0]  cfg_dly_clamped;

    logic [ADDR_BITS-1:0] wp_reg;
    logic [ADDR_BITS-1:0] clr_addr_reg;

    logic [MEM_BITS-1:0]  delay_mem [DELAY_DEPTH];
    logic [MEM_BITS-1:0]  rd_data_reg;
    logic [ADDR_BITS-1:0] mem_addr;
    logic                 mem_we;
    logic                 mem_re;
    logic [MEM_BITS-1:0]  mem_wdata;

    logic signed [SB-1:0]       raw_l_reg, raw_r_reg;
    logic [POS_BITS-1:0]        pos_reg;
    logic [DLY_BITS:0]          pos_diff, pos_wrap;
    logic [POS_BITS-1:0]        pos_next;
    logic [GAIN_BITS:0]         gain_l;
    logic signed [WP_BITS-1:0]  wprod_l_reg, wprod_r_reg;
    logic signed [WP_BITS-1:0]  wrnd_l, wrnd_r, wsh_l, wsh_r;
    logic signed [SB-1:0]       w_l_reg, w_r_reg;
    logic                       meet_reg;
    logic [ADDR_BITS-1:0]       rd0_addr, rd1_addr;
    logic [MEM_BITS-1:0]        e0_reg;

    logic signed [SB-1:0]       a_l, a_r, b_l, b_r;
    logic signed [SB:0]         ip_diff_l, ip_diff_r;
    logic signed [IP_BITS-1:0]  ip_prod_l_reg, ip_prod_r_reg;
    logic signed [IP_BITS-1:0]  ip_sh_l, ip_sh_r;
    logic signed [SB:0]         d_l_reg, d_r_reg;

    logic signed [SB+1:0]       mdiff_l, mdiff_r;
    logic signed [MX_BITS-1:0]  mix_prod_l_reg, mix_prod_r_reg;
    logic signed [FB_BITS-1:0]  fb_prod_l_reg, fb_prod_r_reg;
    logic signed [MX_BITS-1:0]  mix_sh_l, mix_sh_r;
    logic signed [FB_BITS-1:0]  fb_sh_l, fb_sh_r;
    logic signed [SUM_BITS-1:0] res_sum_l, res_sum_r, wb_sum_l, wb_sum_r;
    logic [SB-1:0]              res_l_reg, res_r_reg, wb_l_reg, wb_r_reg;
    logic [SB-1:0]              out_l_reg, out_r_reg;

    // Configuration writes.
    assign cfg_gain         = cfg_wdata[GAIN_BITS:0];
    assign cfg_gain_clamped = (cfg_gain > GAIN_ONE) ? GAIN_ONE : cfg_gain;
    assign cfg_dly_clamped  = (cfg_wdata > DELAY_SPAN) ? DELAY_SPAN : cfg_wdata;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bal_reg <= BALANCE_RST;
            dly_reg <= DELAY_RST;
            fb_reg  <= FEEDBACK_RST;
            mix_reg <= MIX_RST;
        end else if (cfg_we) begin
            case (cfg_idx_t'(cfg_index))
                CFG_BALANCE:  bal_reg <= cfg_gain_clamped;
                CFG_DELAY:    dly_reg <= cfg_dly_clamped;
                CFG_FEEDBACK: fb_reg  <= cfg_wdata[GAIN_BITS-1:0];
                CFG_MIX:      mix_reg <= cfg_gain_clamped;
                default:      ;
            endcase
        end
    end

    // Write pointer and the clearing sweep after reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg       <= '0;
            clr_addr_reg <= '0;
        end else begin
            if (cmd.done) begin
                wp_reg <= wp_reg + ADDR_BITS'(1);
            end
            if (cmd.clear_wr) begin
                clr_addr_reg <= clr_addr_reg + ADDR_BITS'(1);
            end
        end
    end

    assign sts.clear_last = (clr_addr_reg == LAST_ADDR);

    // Single-port delay memory, left sample in the low half.
    assign rd0_addr = pos_reg[POS_BITS-1:FRAC_BITS];
    assign rd1_addr = rd0_addr + ADDR_BITS'(1);

    always_comb begin
        mem_addr  = wp_reg;
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        mem_wdata = {wb_r_reg, wb_l_reg};
        if (cmd.clear_wr) begin
            mem_addr  = clr_addr_reg;
            mem_we    = 1'b1;
            mem_wdata = '0;
        end else if (cmd.rd0) begin
            mem_addr = rd0_addr;
            mem_re   = 1'b1;
        end else if (cmd.rd1) begin
            mem_addr = rd1_addr;
            mem_re   = 1'b1;
        end else if (cmd.done && !meet_reg) begin
            mem_we = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            delay_mem[mem_addr] <= mem_wdata;
        end
        if (mem_re) begin
            rd_data_reg <= delay_mem[mem_addr];
        end
    end

    // Read position and balance weighting.
    assign pos_diff = {2'b00, wp_reg, {FRAC_BITS{1'b0}}} - {1'b0, dly_reg};
    assign pos_wrap = pos_diff + {1'b0, DELAY_SPAN};
    assign pos_next = pos_diff[DLY_BITS] ? pos_wrap[POS_BITS-1:0] : pos_diff[POS_BITS-1:0];
    assign gain_l   = GAIN_ONE - bal_reg;

    assign wrnd_l = wprod_l_reg + WP_HALF;
    assign wrnd_r = wprod_r_reg + WP_HALF;
    assign wsh_l  = wrnd_l >>> GAIN_BITS;
    assign wsh_r  = wrnd_r >>> GAIN_BITS;

    // Linear interpolation between the two neighboring entries.
    assign a_l = $signed(e0_reg[SB-1:0]);
    assign a_r = $signed(e0_reg[MEM_BITS-1:SB]);
    assign b_l = $signed(rd_data_reg[SB-1:0]);
    assign b_r = $signed(rd_data_reg[MEM_BITS-1:SB]);
    assign ip_diff_l = $signed({b_l[SB-1], b_l}) - $signed({a_l[SB-1], a_l});
    assign ip_diff_r = $signed({b_r[SB-1], b_r}) - $signed({a_r[SB-1], a_r});
    assign ip_sh_l   = (ip_prod_l_reg + IP_HALF) >>> FRAC_BITS;
    assign ip_sh_r   = (ip_prod_r_reg + IP_HALF) >>> FRAC_BITS;

    // Wet/dry mix and cross feedback.
    assign mdiff_l  = $signed({d_l_reg[SB], d_l_reg}) - $signed({{2{w_l_reg[SB-1]}}, w_l_reg});
    assign mdiff_r  = $signed({d_r_reg[SB], d_r_reg}) - $signed({{2{w_r_reg[SB-1]}}, w_r_reg});
    assign mix_sh_l = (mix_prod_l_reg + MX_HALF) >>> GAIN_BITS;
    assign mix_sh_r = (mix_prod_r_reg + MX_HALF) >>> GAIN_BITS;
    assign fb_sh_l  = (fb_prod_l_reg + FB_HALF) >>> GAIN_BITS;
    assign fb_sh_r  = (fb_prod_r_reg + FB_HALF) >>> GAIN_BITS;

    assign res_sum_l = $signed({{3{w_l_reg[SB-1]}}, w_l_reg}) + $signed(mix_sh_l[SUM_BITS-1:0]);
    assign res_sum_r = $signed({{3{w_r_reg[SB-1]}}, w_r_reg}) + $signed(mix_sh_r[SUM_BITS-1:0]);
    assign wb_sum_l  = $signed({{3{w_l_reg[SB-1]}}, w_l_reg}) + $signed(fb_sh_l[SUM_BITS-1:0]);
    assign wb_sum_r  = $signed({{3{w_r_reg[SB-1]}}, w_r_reg}) + $signed(fb_sh_r[SUM_BITS-1:0]);

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            raw_l_reg <= s_in_left;
            raw_r_reg <= s_in_right;
        end
        if (cmd.pos) begin
            pos_reg     <= pos_next;
            wprod_l_reg <= raw_l_reg * $signed({1'b0, gain_l});
            wprod_r_reg <= raw_r_reg * $signed({1'b0, bal_reg});
        end
        if (cmd.rd0) begin
            w_l_reg  <= wsh_l[SB-1:0];
            w_r_reg  <= wsh_r[SB-1:0];
            meet_reg <= (rd0_addr == wp_reg);
        end
        if (cmd.rd1) begin
            e0_reg <= rd_data_reg;
        end
        if (cmd.interp) begin
            ip_prod_l_reg <= ip_diff_l * $signed({1'b0, pos_reg[FRAC_BITS-1:0]});
            ip_prod_r_reg <= ip_diff_r * $signed({1'b0, pos_reg[FRAC_BITS-1:0]});
        end
        if (cmd.blend) begin
            d_l_reg <= $signed({a_l[SB-1], a_l}) + $signed(ip_sh_l[SB:0]);
            d_r_reg <= $signed({a_r[SB-1], a_r}) + $signed(ip_sh_r[SB:0]);
        end
        if (cmd.mix) begin
            mix_prod_l_reg <= mdiff_l * $signed({1'b0, mix_reg});
            mix_prod_r_reg <= mdiff_r * $signed({1'b0, mix_reg});
            fb_prod_l_reg  <= d_r_reg * $signed({1'b0, fb_reg});
            fb_prod_r_reg  <= d_l_reg * $signed({1'b0, fb_reg});
        end
        if (cmd.finish) begin
            res_l_reg <= sat_sample(res_sum_l);
            res_r_reg <= sat_sample(res_sum_r);
            wb_l_reg  <= sat_sample(wb_sum_l);
            wb_r_reg  <= sat_sample(wb_sum_r);
        end
        if (cmd.done) begin
            out_l_reg <= meet_reg ? raw_l_reg : res_l_reg;
            out_r_reg <= meet_reg ? raw_r_reg : res_r_reg;
        end
    end

    assign m_out_left  = $signed(out_l_reg);
    assign m_out_right = $signed(out_r_reg);

endmodule

// File: hdl/stereo_ping_pong_delay_top.sv
// Top level of the stereo ping-pong delay: controller and datapath.
//
// One stereo word in, one stereo word out. After reset the block sweeps the whole delay
// memory to zero, one entry per cycle, and takes no input word until the sweep is done;
// configuration writes are taken at any time. Each word runs all its steps before the next
// is accepted: the two interpolation reads share the single memory port, the balance and
// interpolation products each get their own registered step, and the mix and feedback
// products share one. A finished word sits in the output register while the next input
// word is accepted; it stalls only when a second result is ready before the first is taken.
module stereo_ping_pong_delay_top (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   cfg_we,
    input  logic [spd_pkg::CFG_IDX_BITS-1:0]       cfg_index,
    input  logic [spd_pkg::CFG_BITS-1:0]           cfg_wdata,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic signed [spd_pkg::SAMPLE_BITS-1:0] s_in_left,
    input  logic signed [spd_pkg::SAMPLE_BITS-1:0] s_in_right,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic signed [spd_pkg::SAMPLE_BITS-1:0] m_out_left,
    output logic signed [spd_pkg::SAMPLE_BITS-1:0] m_out_right
);
    import spd_pkg::*;

    dp_cmd_t cmd;
    dp_sts_t sts;

    spd_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    spd_datapath u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .sts         (sts),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .s_in_left   (s_in_left),
        .s_in_right  (s_in_right),
        .m_out_left  (m_out_left),
        .m_out_right (m_out_right)
    );

endmodule

// File: hdl/spd_checker.sv
// Port-level assertions for the stereo ping-pong delay and their binding to the top level.
module spd_checker (
    input logic                                   aclk,
    input logic                                   aresetn,
    input logic                                   s_valid,
    input logic                                   s_ready,
    input logic                                   m_valid,
    input logic                                   m_ready,
    input logic signed [spd_pkg::SAMPLE_BITS-1:0] m_out_left,
    input logic signed [spd_pkg::SAMPLE_BITS-1:0] m_out_right
);

    a_reset_clears_out: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("Output word valid right after reset.");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("Input ready again right after a word was accepted.");

    a_result_from_work: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(!s_ready))
        else $error("Output word appeared without a word in progress.");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_left) && $stable(m_out_right))
        else $error("Stalled output word changed or was dropped.");

endmodule

bind stereo_ping_pong_delay_top spd_checker u_spd_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_valid     (s_valid),
    .s_ready     (s_ready),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_out_left  (m_out_left),
    .m_out_right (m_out_right)
);

// File: bench/tb_top.sv
// Self-checking testbench for the stereo ping-pong delay: directed table, then random phases.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import spd_pkg::*;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;

    typedef struct {
        sample_t left;
        sample_t right;
    } pair_t;

    typedef struct {
        bit                  is_cfg;
        cfg_idx_t            idx;
        logic [CFG_BITS-1:0] value;
        sample_t             l;
        sample_t             r;
        bit                  typed;
        sample_t             want_l;
        sample_t             want_r;
    } plan_row_t;

    logic                        aclk        = 1'b0;
    logic                        aresetn     = 1'b0;
    logic                        cfg_we      = 1'b0;
    logic [CFG_IDX_BITS-1:0]     cfg_index   = '0;
    logic [CFG_BITS-1:0]         cfg_wdata   = '0;
    logic                        s_valid     = 1'b0;
    logic                        s_ready;
    sample_t                     s_in_left   = '0;
    sample_t                     s_in_right  = '0;
    logic                        m_valid;
    logic                        m_ready     = 1'b0;
    sample_t                     m_out_left;
    sample_t                     m_out_right;

    bit [MEM_BITS-1:0]  delay_copy [DELAY_DEPTH];
    bit [ADDR_BITS-1:0] write_ptr    = '0;
    bit [GAIN_BITS:0]   cur_balance  = BALANCE_RST;
    bit [DLY_BITS-1:0]  cur_delay    = DELAY_RST;
    bit [GAIN_BITS-1:0] cur_feedback = FEEDBACK_RST;
    bit [GAIN_BITS:0]   cur_mix      = MIX_RST;

    pair_t     pending_pairs [$];
    plan_row_t plan [$];
    bit        gaps_on      = 1'b1;
    int        mismatches   = 0;
    int        words_sent   = 0;
    int        results_seen = 0;
    int        cfg_writes   = 0;
    int        passthroughs = 0;
    int        saturated    = 0;

    stereo_ping_pong_delay_top u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_in_left   (s_in_left),
        .s_in_right  (s_in_right),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_left  (m_out_left),
        .m_out_right (m_out_right)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    function automatic longint scale_down(longint v, int n);
        return (v + (longint'(1) <<< (n - 1))) >>> n;
    endfunction

    function automatic sample_t clip(longint v);
        longint hi;
        longint lo;
        hi = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
        lo = -hi - 1;
        if (v > hi) begin
            saturated++;
            return sample_t'(hi);
        end
        if (v < lo) begin
            saturated++;
            return sample_t'(lo);
        end
        return sample_t'(v);
    endfunction

    function automatic pair_t echo_step(sample_t in_l, sample_t in_r);
        longint one, span, bal, mix, fb, dly, pos, frac;
        longint raw_l, raw_r, w_l, w_r, a_l, a_r, b_l, b_r, d_l, d_r;
        bit [ADDR_BITS-1:0] rd0, rd1;
        bit [MEM_BITS-1:0]  e0, e1;
        sample_t            m_l, m_r;
        pair_t              res;
        one   = GAIN_ONE;
        span  = DELAY_SPAN;
        raw_l = in_l;
        raw_r = in_r;
        bal   = (cur_balance > GAIN_ONE) ? one : longint'(cur_balance);
        mix   = (cur_mix > GAIN_ONE) ? one : longint'(cur_mix);
        fb    = longint'(cur_feedback);
        dly   = (cur_delay > DELAY_SPAN) ? span : longint'(cur_delay);
        pos   = (longint'(write_ptr) <<< FRAC_BITS) + span - dly;
        if (pos >= span) begin
            pos = pos - span;
        end
        rd0       = ADDR_BITS'(pos >>> FRAC_BITS);
        res.left  = in_l;
        res.right = in_r;
        if (rd0 == write_ptr) begin
            passthroughs++;
        end else begin
            w_l  = scale_down(raw_l * (one - bal), GAIN_BITS);
            w_r  = scale_down(raw_r * bal, GAIN_BITS);
            frac = pos & ((longint'(1) <<< FRAC_BITS) - 1);
            rd1  = rd0 + 1'b1;
            e0   = delay_copy[rd0];
            e1   = delay_copy[rd1];
            a_l  = $signed(e0[SAMPLE_BITS-1:0]);
            a_r  = $signed(e0[MEM_BITS-1:SAMPLE_BITS]);
            b_l  = $signed(e1[SAMPLE_BITS-1:0]);
            b_r  = $signed(e1[MEM_BITS-1:SAMPLE_BITS]);
            d_l  = a_l + scale_down((b_l - a_l) * frac, FRAC_BITS);
            d_r  = a_r + scale_down((b_r - a_r) * frac, FRAC_BITS);
            res.left  = clip(w_l + scale_down((d_l - w_l) * mix, GAIN_BITS));
            res.right = clip(w_r + scale_down((d_r - w_r) * mix, GAIN_BITS));
            m_l = clip(w_l + scale_down(d_r * fb, GAIN_BITS));
            m_r = clip(w_r + scale_down(d_l * fb, GAIN_BITS));
            delay_copy[write_ptr] = {m_r, m_l};
        end
        write_ptr = write_ptr + 1'b1;
        return res;
    endfunction

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 50) begin
            return 0;
        end else if (roll < 85) begin
            return $urandom_range(1, 3);
        end else if (roll < 97) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    function automatic sample_t pick_sample();
        case ($urandom_range(0, 9))
            0: begin
                return 24'h7FFFFF;
            end
            1: begin
                return 24'h800000;
            end
            2: begin
                return '0;
            end
            3: begin
                return sample_t'(int'($urandom_range(0, 511)) - 256);
            end
            default: begin
                return sample_t'($urandom);
            end
        endcase
    endfunction

    function automatic logic [CFG_BITS-1:0] pick_gain();
        case ($urandom_range(0, 5))
            0: begin
                return '0;
            end
            1: begin
                return CFG_BITS'(GAIN_ONE);
            end
            2: begin
                return CFG_BITS'($urandom_range(0, 131071));
            end
            3: begin
                return CFG_BITS'($urandom);
            end
            default: begin
                return CFG_BITS'($urandom_range(0, 65536));
            end
        endcase
    endfunction

    function automatic plan_row_t known_row(sample_t l, sample_t r, sample_t wl, sample_t wr);
        plan_row_t row;
        row.is_cfg = 1'b0;
        row.idx    = CFG_BALANCE;
        row.value  = '0;
        row.l      = l;
        row.r      = r;
        row.typed  = 1'b1;
        row.want_l = wl;
        row.want_r = wr;
        return row;
    endfunction

    function automatic plan_row_t word_row(sample_t l, sample_t r);
        plan_row_t row;
        row       = known_row(l, r, '0, '0);
        row.typed = 1'b0;
        return row;
    endfunction

    function automatic plan_row_t cfg_row(cfg_idx_t idx, logic [CFG_BITS-1:0] value);
        plan_row_t row;
        row        = word_row('0, '0);
        row.is_cfg = 1'b1;
        row.idx    = idx;
        row.value  = value;
        return row;
    endfunction

    task automatic report_mismatch(string msg);
        mismatches++;
        if (mismatches <= 50) begin
            $display("[%0t] MISMATCH %s", $realtime, msg);
        end
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [CFG_BITS-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we <= 1'b0;
        @(posedge aclk);
        case (idx)
            CFG_BALANCE: begin
                cur_balance = value[GAIN_BITS:0];
            end
            CFG_DELAY: begin
                cur_delay = value;
            end
            CFG_FEEDBACK: begin
                cur_feedback = value[GAIN_BITS-1:0];
            end
            CFG_MIX: begin
                cur_mix = value[GAIN_BITS:0];
            end
            default: begin
            end
        endcase
        cfg_writes++;
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        while (pending_pairs.size() != 0) begin
            @(posedge aclk);
        end
        repeat (3) @(posedge aclk);
    endtask

    task automatic send_pair(sample_t l, sample_t r, bit typed, sample_t want_l,
                             sample_t want_r);
        int    gap;
        pair_t predicted;
        gap = gaps_on ? pick_gap() : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid    <= 1'b1;
        s_in_left  <= l;
        s_in_right <= r;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        predicted = echo_step(l, r);
        if (typed) begin
            predicted.left  = want_l;
            predicted.right = want_r;
        end
        pending_pairs.push_back(predicted);
        words_sent++;
    endtask

    initial begin
        int    stall_left;
        int    mode_left;
        bit    stall_mode;
        pair_t want;
        stall_left = 0;
        mode_left  = 0;
        stall_mode = 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                results_seen++;
                if (pending_pairs.size() == 0) begin
                    report_mismatch($sformatf("word %0d: %0d/%0d with nothing outstanding",
                                              results_seen, m_out_left, m_out_right));
                end else begin
                    want = pending_pairs.pop_front();
                    if (m_out_left !== want.left) begin
                        report_mismatch($sformatf("word %0d out_left: got %0d, want %0d",
                                                  results_seen, m_out_left, want.left));
                    end
                    if (m_out_right !== want.right) begin
                        report_mismatch($sformatf("word %0d out_right: got %0d, want %0d",
                                                  results_seen, m_out_right, want.right));
                    end
                end
            end
            if (mode_left == 0) begin
                stall_mode = ($urandom_range(0, 2) != 0);
                mode_left  = $urandom_range(50, 400);
            end
            mode_left--;
            if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else begin
                stall_left = stall_mode ? pick_gap() : 0;
                m_ready <= (stall_left == 0);
            end
        end
    end

    initial begin
        int phase_len;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        plan = '{
            known_row(24'h7FFFFF, 24'h800000, 24'h000000, 24'h000000),
            known_row(24'h800000, 24'h7FFFFF, 24'h000000, 24'h000000),
            known_row(24'h000000, 24'h000000, 24'h000000, 24'h000000),
            cfg_row(CFG_DELAY, '0),
            known_row(24'h7FFFFF, 24'h800000, 24'h7FFFFF, 24'h800000),
            known_row(24'h800000, 24'h7FFFFF, 24'h800000, 24'h7FFFFF),
            known_row(24'hFFFFFF, 24'h000001, 24'hFFFFFF, 24'h000001),
            cfg_row(CFG_DELAY, DELAY_SPAN),
            known_row(24'h123456, 24'h9ABCDE, 24'h123456, 24'h9ABCDE),
            cfg_row(CFG_DELAY, {CFG_BITS{1'b1}}),
            known_row(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF),
            cfg_row(CFG_DELAY, 27'd256),
            cfg_row(CFG_BALANCE, '0),
            cfg_row(CFG_FEEDBACK, 27'd58982),
            word_row(24'h7FFFFF, 24'h7FFFFF),
            word_row(24'h800000, 24'h800000),
            word_row(24'h400000, 24'hC00000),
            word_row(24'h000001, 24'hFFFFFF),
            cfg_row(CFG_MIX, '0),
            cfg_row(CFG_BALANCE, 27'd65536),
            known_row(24'h7FFFFF, 24'h800000, 24'h000000, 24'h800000),
            known_row(24'h800000, 24'h7FFFFF, 24'h000000, 24'h7FFFFF),
            cfg_row(CFG_BALANCE, 27'h1FFFF),
            cfg_row(CFG_MIX, 27'h1FFFF),
            cfg_row(CFG_FEEDBACK, 27'hFFFF),
            cfg_row(CFG_DELAY, 27'd384),
            word_row(24'h7FFFFF, 24'h800000),
            word_row(24'h7FFFFF, 24'h7FFFFF),
            word_row(24'h800000, 24'h800000),
            word_row(24'h2AAAAA, 24'hD55555),
            cfg_row(CFG_DELAY, 27'd128),
            word_row(24'h7FFFFF, 24'h800000),
            word_row(24'h355555, 24'h0AAAAA),
            cfg_row(CFG_DELAY, 27'h3FFFF00),
            word_row(24'h654321, 24'h876543),
            word_row(24'h000000, 24'h7FFFFF)
        };

        foreach (plan[i]) begin
            if (plan[i].is_cfg) begin
                drain_results();
                write_reg(plan[i].idx, plan[i].value);
            end else begin
                send_pair(plan[i].l, plan[i].r, plan[i].typed, plan[i].want_l, plan[i].want_r);
            end
        end

        while (words_sent < 1700) begin
            drain_results();
            write_reg(CFG_BALANCE, pick_gain());
            write_reg(CFG_MIX, pick_gain());
            case ($urandom_range(0, 5))
                0: begin
                    write_reg(CFG_FEEDBACK, '0);
                end
                1: begin
                    write_reg(CFG_FEEDBACK, 27'd58982);
                end
                2: begin
                    write_reg(CFG_FEEDBACK, 27'hFFFF);
                end
                3: begin
                    write_reg(CFG_FEEDBACK, CFG_BITS'($urandom));
                end
                default: begin
                    write_reg(CFG_FEEDBACK, CFG_BITS'($urandom_range(0, 58982)));
                end
            endcase
            case ($urandom_range(0, 11))
                0: begin
                    write_reg(CFG_DELAY, '0);
                end
                1: begin
                    write_reg(CFG_DELAY, DELAY_SPAN);
                end
                2: begin
                    write_reg(CFG_DELAY, CFG_BITS'($urandom));
                end
                3: begin
                    write_reg(CFG_DELAY, CFG_BITS'($urandom_range(1, 255)));
                end
                4: begin
                    write_reg(CFG_DELAY, DELAY_SPAN - CFG_BITS'($urandom_range(0, 1023)));
                end
                5: begin
                    write_reg(CFG_DELAY, CFG_BITS'($urandom_range(0, 67108864)));
                end
                default: begin
                    write_reg(CFG_DELAY, CFG_BITS'($urandom_range(256, 16384)));
                end
            endcase
            gaps_on   = ($urandom_range(0, 3) != 0);
            phase_len = $urandom_range(40, 160);
            repeat (phase_len) begin
                send_pair(pick_sample(), pick_sample(), 1'b0, '0, '0);
            end
        end

        drain_results();
        repeat (20) @(posedge aclk);

        $display("Sent %0d stereo words over %0d register writes; %0d read-meets-write words.",
                 words_sent, cfg_writes, passthroughs);
        $display("Compared %0d results, %0d saturated values predicted, %0d mismatches.",
                 results_seen, saturated, mismatches);
        if (mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial begin
        #10000000;
        $display("Timeout with %0d results outstanding.", pending_pairs.size());
        $display("Simulation FAILED");
        $finish;
    end

endmodule
